[design/pkm_pkg.sv]
// ----------------------------------------------------------------------------
// pkm_pkg: shared types and constants for the peer keepalive monitor
// Payload structs, opcode and event codes, sequencer states.
// ----------------------------------------------------------------------------
package pkm_pkg;

  localparam int unsigned PeerSlotsDef = 16;
  localparam int unsigned MaxOut       = 16;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [1:0] OpTick     = 2'd0;
  localparam logic [1:0] OpAdd      = 2'd1;
  localparam logic [1:0] OpResponse = 2'd2;
  localparam logic [1:0] OpUnused   = 2'd3;

  localparam logic [CfgIdxW-1:0] RegPeriodic = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTransmit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRetry    = 2'd2;

  localparam logic [2:0] EvAdded     = 3'd0;
  localparam logic [2:0] EvRestarted = 3'd1;
  localparam logic [2:0] EvFull      = 3'd2;
  localparam logic [2:0] EvReply     = 3'd3;
  localparam logic [2:0] EvUnknown   = 3'd4;
  localparam logic [2:0] EvEcho      = 3'd5;
  localparam logic [2:0] EvDown      = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] peer_addr;
    logic [1:0]  peer_kind;
  } pkm_in_t;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [31:0] out_addr;
    logic [1:0]  out_kind;
    logic [15:0] seq_num;
    logic        last;
  } pkm_out_t;

  typedef enum logic [2:0] {
    StIdle, StScan, StTick, StFinish, StEmit
  } pkm_state_e;

endpackage

[design/peer_keepalive_monitor_top.sv]
// ----------------------------------------------------------------------------
// peer_keepalive_monitor_top: echo-request supervision of a peer table
// Sequencer walks the peer table one slot per cycle, unless the output stalls a tick, with one shared compare.
// ----------------------------------------------------------------------------
// A tick walks the slots; its results leave through the output register
// while the walk goes on. An add or a response walks the slots in a scan,
// then passes through an update state and a state that holds its result.
// An unused opcode is taken and gives no result. Result-side stalls hold
// a tick's walk and the result state, and in_stall_o is high meanwhile.
// Slots are visited one per clock, unless the output stalls a tick, through
// a single address compare and countdown unit; each result is held in an
// output register until taken. No clearing pass.
module peer_keepalive_monitor_top #(
  parameter int unsigned PEER_SLOTS = pkm_pkg::PeerSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pkm_pkg::pkm_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pkm_pkg::pkm_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pkm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pkm_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(PEER_SLOTS + 1);

  logic [15:0] periodic_q, transmit_q;
  logic [7:0]  retry_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q  <= 16'd60;
      transmit_q  <= 16'd5;
      retry_lim_q <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pkm_pkg::RegPeriodic: periodic_q  <= cfg_data_i;
        pkm_pkg::RegTransmit: transmit_q  <= cfg_data_i;
        pkm_pkg::RegRetry:    retry_lim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // slot table
  logic [PEER_SLOTS-1:0] valid_q;
  logic [31:0] addr_q [PEER_SLOTS];
  logic [1:0]  kind_q [PEER_SLOTS];
  logic        wait_q [PEER_SLOTS];
  logic [15:0] cnt_q  [PEER_SLOTS];
  logic [7:0]  rty_q  [PEER_SLOTS];
  logic [15:0] seq_q  [4];

  pkm_pkg::pkm_state_e state_q, state_d;
  pkm_pkg::pkm_in_t    item_q;
  logic [CntW-1:0]     idx_q;
  logic [IdxW-1:0]     hit_q, free_q;
  logic                hit_f_q, free_f_q;
  logic [4:0]          nout_q;
  pkm_pkg::pkm_out_t   res_q;
  logic                res_v_q;

  logic [IdxW-1:0] cur;
  assign cur = idx_q[IdxW-1:0];
  logic at_end;
  assign at_end = (idx_q == CntW'(PEER_SLOTS - 1));

  logic tick_go;
  assign tick_go = (!res_v_q || !out_stall_i) && nout_q != 5'(pkm_pkg::MaxOut);

  // a new result is loaded on the update cycle or on a due slot of a tick
  logic res_set;
  assign res_set = (state_q == pkm_pkg::StFinish) ||
                   (state_q == pkm_pkg::StTick && tick_go && valid_q[cur] &&
                    cnt_q[cur] <= 16'd1);

  assign in_stall_o  = (state_q != pkm_pkg::StIdle) || res_v_q;
  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pkm_pkg::StIdle:
        if (in_valid_i && !in_stall_o) begin
          if (in_data_i.opcode == pkm_pkg::OpTick) state_d = pkm_pkg::StTick;
          else if (in_data_i.opcode == pkm_pkg::OpAdd ||
                   in_data_i.opcode == pkm_pkg::OpResponse)
            state_d = pkm_pkg::StScan;
        end
      pkm_pkg::StScan: if (at_end) state_d = pkm_pkg::StFinish;
      pkm_pkg::StFinish: state_d = pkm_pkg::StEmit;
      pkm_pkg::StEmit: if (!out_stall_i) state_d = pkm_pkg::StIdle;
      pkm_pkg::StTick:
        if (!res_v_q || !out_stall_i) begin
          if (at_end || nout_q == 5'(pkm_pkg::MaxOut)) state_d = pkm_pkg::StIdle;
        end
      default: state_d = pkm_pkg::StIdle;
    endcase
  end

  // last flag for a tick: no later slot can produce a result, or this result is the MaxOut-th
  logic later_due;
  always_comb begin
    later_due = 1'b0;
    for (int j = 0; j < PEER_SLOTS; j++)
      if (CntW'(j) > idx_q && valid_q[j] && cnt_q[j] <= 16'd1) later_due = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (res_set) begin
      res_v_q <= 1'b1;
    end else if (res_v_q && !out_stall_i) begin
      res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pkm_pkg::StIdle;
      valid_q <= '0;
      idx_q   <= '0;
      nout_q  <= '0;
      hit_f_q <= 1'b0;
      free_f_q <= 1'b0;
      seq_q[0] <= 16'd0; seq_q[1] <= 16'd0; seq_q[2] <= 16'd0; seq_q[3] <= 16'd1;
    end else begin
      state_q <= state_d;
      case (state_q)
        pkm_pkg::StIdle: begin
          item_q <= in_data_i;
          idx_q  <= '0;
          nout_q <= '0;
          hit_f_q <= 1'b0;
          free_f_q <= 1'b0;
        end
        pkm_pkg::StScan: begin
          if (valid_q[cur] && addr_q[cur] == item_q.peer_addr && !hit_f_q) begin
            hit_f_q <= 1'b1; hit_q <= cur;
          end
          if (!valid_q[cur] && !free_f_q) begin
            free_f_q <= 1'b1; free_q <= cur;
          end
          idx_q <= idx_q + 1'b1;
        end
        pkm_pkg::StFinish: begin
          res_q.seq_num <= '0;
          res_q.last    <= 1'b1;
          res_q.out_addr <= item_q.peer_addr;
          res_q.out_kind <= hit_f_q ? kind_q[hit_q] : item_q.peer_kind;
          if (hit_f_q) begin
            wait_q[hit_q] <= 1'b0;
            cnt_q[hit_q]  <= periodic_q;
            if (item_q.opcode == pkm_pkg::OpAdd) res_q.event_code <= pkm_pkg::EvRestarted;
            else begin
              rty_q[hit_q] <= '0;
              res_q.event_code <= pkm_pkg::EvReply;
            end
          end else if (item_q.opcode == pkm_pkg::OpAdd) begin
            if (free_f_q) begin
              valid_q[free_q] <= 1'b1;
              addr_q[free_q]  <= item_q.peer_addr;
              kind_q[free_q]  <= item_q.peer_kind;
              rty_q[free_q]   <= '0;
              wait_q[free_q]  <= 1'b0;
              cnt_q[free_q]   <= periodic_q;
              res_q.event_code <= pkm_pkg::EvAdded;
            end else res_q.event_code <= pkm_pkg::EvFull;
          end else res_q.event_code <= pkm_pkg::EvUnknown;
        end
        pkm_pkg::StTick: begin
          if (tick_go) begin
            idx_q <= idx_q + 1'b1;
            if (valid_q[cur]) begin
              if (cnt_q[cur] > 16'd1) cnt_q[cur] <= cnt_q[cur] - 16'd1;
              else begin
                nout_q <= nout_q + 5'd1;
                res_q.out_addr <= addr_q[cur];
                res_q.out_kind <= kind_q[cur];
                res_q.last <= !later_due || (nout_q == 5'(pkm_pkg::MaxOut - 1));
                if (rty_q[cur] == retry_lim_q) begin
                  valid_q[cur] <= 1'b0;
                  res_q.event_code <= pkm_pkg::EvDown;
                  res_q.seq_num <= '0;
                end else begin
                  res_q.event_code <= pkm_pkg::EvEcho;
                  cnt_q[cur] <= transmit_q;
                  if (!wait_q[cur]) begin
                    wait_q[cur] <= 1'b1;
                    seq_q[kind_q[cur]] <= seq_q[kind_q[cur]] + 16'd1;
                    res_q.seq_num <= seq_q[kind_q[cur]] + 16'd1;
                  end else begin
                    rty_q[cur] <= rty_q[cur] + 8'd1;
                    res_q.seq_num <= seq_q[kind_q[cur]];
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pkm_pkg::StIdle) |-> in_stall_o) else $error("accept while busy");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");
  a_nout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nout_q <= 5'(pkm_pkg::MaxOut)) else $error("too many results");

endmodule
